@@ rtl/stpm_pkg.sv @@
// Shared types, constants and curve tables of the stick-to-pointer motion block.
package stpm_pkg;

   localparam int CurveBits    = 8;
   localparam int CurveEntries = 1 << CurveBits;
   localparam logic [14:0] FullScale        = 15'd32767;
   localparam logic [14:0] DefaultPointerDz = 15'd6000;
   localparam logic [14:0] DefaultScrollDz  = 15'd5000;

   localparam logic [2:0] CsrSwapSticks     = 3'd0;
   localparam logic [2:0] CsrPointerDz      = 3'd1;
   localparam logic [2:0] CsrScrollDz       = 3'd2;
   localparam logic [2:0] CsrPointerGain    = 3'd3;
   localparam logic [2:0] CsrScrollGain     = 3'd4;
   localparam logic [2:0] CsrCurveExponent  = 3'd5;

   typedef struct packed {
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
   } stpm_req_type;

   typedef struct packed {
      logic signed [15:0] pointer_step_x;
      logic signed [15:0] pointer_step_y;
      logic signed [15:0] scroll_horizontal;
      logic               scroll_horizontal_valid;
      logic signed [15:0] scroll_vertical;
      logic               scroll_vertical_valid;
   } stpm_rsp_type;

   typedef struct packed {
      logic        swap_sticks;
      logic [14:0] pointer_dead_zone;
      logic [14:0] wheel_dead_zone;
      logic [15:0] pointer_gain;
      logic [15:0] scroll_gain;
      logic [11:0] curve_exponent;
   } stpm_cfg_type;

   // Classified sample handed from the front to the back.
   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic [14:0]        pdz;
      logic [14:0]        sdz;
      logic [15:0]        smx;
      logic [15:0]        smy;
      logic               hen;
      logic               ven;
   } stpm_job_type;

   typedef logic [15:0] log_tab_type [CurveEntries];
   typedef logic [16:0] exp_tab_type [CurveEntries];
   typedef logic [63:0] root_type [17];

   function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bv;
      v  = v_in;
      r  = '0;
      bv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bv > v) bv = bv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bv != 0) begin
            if (v >= r + bv) begin
               v = v - (r + bv);
               r = (r >> 1) + bv;
            end else begin
               r = r >> 1;
            end
            bv = bv >> 2;
         end
      end
      return r;
   endfunction

   function automatic log_tab_type build_log();
      log_tab_type t;
      logic [63:0] y;
      logic [15:0] res;
      for (int i = 0; i < CurveEntries; i++) begin
         y   = (64'd1 << 30) + ((64'(i) << 30) / CurveEntries);
         res = '0;
         for (int k = 1; k <= 16; k++) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
               y = y >> 1;
               res[16-k] = 1'b1;
            end
         end
         t[i] = res;
      end
      return t;
   endfunction

   function automatic exp_tab_type build_exp();
      exp_tab_type t;
      root_type    rt;
      logic [63:0] f16;
      logic [63:0] r;
      rt[0] = '0;
      rt[1] = isqrt_const(64'd1 << 61);
      for (int k = 2; k <= 16; k++) rt[k] = isqrt_const(rt[k-1] << 30);
      for (int i = 0; i < CurveEntries; i++) begin
         f16 = (64'(i) << 16) / CurveEntries;
         r   = 64'd1 << 30;
         for (int k = 1; k <= 16; k++) begin
            if (f16[16-k]) r = (r * rt[k]) >> 30;
         end
         t[i] = 17'(r >> 14);
      end
      return t;
   endfunction

   localparam log_tab_type LogTab = build_log();
   localparam exp_tab_type ExpTab = build_exp();

endpackage

@@ rtl/stpm_front.sv @@
// Front end: takes samples, picks pointer and scroll sticks, resolves dead zones.
module stpm_front import stpm_pkg::*; (
   input  logic         req_valid,
   output logic         req_stall,
   input  stpm_req_type req_data,
   input  stpm_cfg_type cfg,
   input  logic         q_full,
   output logic         q_push,
   output stpm_job_type q_job
);

   logic [16:0] ax_x;
   logic [16:0] ax_y;
   logic [15:0] mx;
   logic [15:0] my;
   logic        hen;
   logic        ven;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_job.px  = cfg.swap_sticks ? req_data.right_x : req_data.left_x;
      q_job.py  = cfg.swap_sticks ? req_data.right_y : req_data.left_y;
      q_job.sx  = cfg.swap_sticks ? req_data.left_x  : req_data.right_x;
      q_job.sy  = cfg.swap_sticks ? req_data.left_y  : req_data.right_y;
      q_job.pdz = (cfg.pointer_dead_zone == '0) ? DefaultPointerDz : cfg.pointer_dead_zone;
      q_job.sdz = (cfg.wheel_dead_zone == '0) ? DefaultScrollDz : cfg.wheel_dead_zone;
      ax_x = q_job.sx[15] ? (17'd0 - 17'(q_job.sx)) : 17'(q_job.sx);
      ax_y = q_job.sy[15] ? (17'd0 - 17'(q_job.sy)) : 17'(q_job.sy);
      mx   = ax_x[15:0];
      my   = ax_y[15:0];
      hen  = mx > 16'(q_job.sdz);
      ven  = my > 16'(q_job.sdz);
      // keep only the dominant axis; on a tie the vertical one wins
      if (hen && ven) begin
         if (mx > my) ven = 1'b0;
         else hen = 1'b0;
      end
      q_job.smx = mx;
      q_job.smy = my;
      q_job.hen = hen;
      q_job.ven = ven;
   end

endmodule

@@ rtl/stpm_queue.sv @@
// Two-entry queue between the front and the back.
module stpm_queue import stpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  stpm_job_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output stpm_job_type head_data
);

   stpm_job_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2) || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a write");

endmodule

@@ rtl/stpm_back.sv @@
// Back end: sequencer with shared multiplier, square root and divider steps.
module stpm_back import stpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  stpm_cfg_type cfg,
   input  logic         q_valid,
   input  stpm_job_type q_job,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output stpm_rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_DZSQ, S_SQRT, S_NRM, S_DIV, S_NDONE,
      S_CV1, S_CV2, S_CV3, S_P1, S_P2, S_P3, S_SC, S_SM1, S_SM2, S_SM3, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   stpm_job_type        job_ff, job_in;
   logic                axis_ff, axis_in;
   logic                tgt_ff, tgt_in;
   logic [31:0]         lsq_ff, lsq_in;
   logic [31:0]         sqv_ff, sqv_in;
   logic [31:0]         sqr_ff, sqr_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic [15:0]         mag_ff, mag_in;
   logic [14:0]         dz_ff, dz_in;
   logic [14:0]         den_ff, den_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         nrm_ff, nrm_in;
   logic [20:0]         lval_ff, lval_in;
   logic [24:0]         pval_ff, pval_in;
   logic signed [32:0]  tn_ff, tn_in;
   logic signed [51:0]  prod_ff, prod_in;
   logic [15:0]         fracx_ff, fracx_in;
   logic [15:0]         fracy_ff, fracy_in;
   logic signed [15:0]  stepx_ff, stepx_in;
   logic signed [15:0]  stepy_ff, stepy_in;
   logic signed [15:0]  hval_ff, hval_in;
   logic signed [15:0]  vval_ff, vval_in;
   stpm_rsp_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic signed [33:0]  mul_a;
   logic signed [17:0]  mul_b;
   logic signed [51:0]  mul_p;

   logic [4:0]          sq_shift;
   logic [31:0]         sq_bit;
   logic [32:0]         sq_try;
   logic [31:0]         sq_r_next;
   logic [16:0]         rem2;
   logic [15:0]         num;
   logic [3:0]          msb;
   logic [23:0]         idx_word;
   logic [25:0]         p_round;
   logic [9:0]          s_val;
   logic [25:0]         f_word;
   logic [16:0]         exp_val;
   logic [35:0]         dq;
   logic [36:0]         acc;
   logic [51:0]         abs_p;
   logic [20:0]         trunc_v;
   logic                out_free;

   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      if (v > 21'sd32767) return 16'sh7fff;
      if (v < -21'sd32768) return -16'sh8000;
      return v[15:0];
   endfunction

   assign mul_p     = mul_a * mul_b;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      unique case (state_ff)
         S_SQX:   begin mul_a = 34'(job_ff.px); mul_b = 18'(job_ff.px); end
         S_SQY:   begin mul_a = 34'(job_ff.py); mul_b = 18'(job_ff.py); end
         S_DZSQ:  begin mul_a = 34'(job_ff.pdz); mul_b = 18'(job_ff.pdz); end
         S_CV2:   begin mul_a = 34'(lval_ff); mul_b = 18'(cfg.curve_exponent); end
         S_P1:    begin mul_a = axis_ff ? 34'(job_ff.py) : 34'(job_ff.px);
                        mul_b = 18'(nrm_ff); end
         S_P2:    begin mul_a = 34'(tn_ff); mul_b = 18'(cfg.pointer_gain); end
         S_SM1:   begin mul_a = axis_ff ? 34'(job_ff.sy) : 34'(job_ff.sx);
                        mul_b = 18'(nrm_ff); end
         S_SM2:   begin mul_a = 34'(tn_ff); mul_b = 18'(cfg.scroll_gain); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      axis_in      = axis_ff;
      tgt_in       = tgt_ff;
      lsq_in       = lsq_ff;
      sqv_in       = sqv_ff;
      sqr_in       = sqr_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      dz_in        = dz_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      nrm_in       = nrm_ff;
      lval_in      = lval_ff;
      pval_in      = pval_ff;
      tn_in        = tn_ff;
      prod_in      = prod_ff;
      fracx_in     = fracx_ff;
      fracy_in     = fracy_ff;
      stepx_in     = stepx_ff;
      stepy_in     = stepy_ff;
      hval_in      = hval_ff;
      vval_in      = vval_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      sq_shift  = 5'd30 - {cnt_ff, 1'b0};
      sq_bit    = 32'd1 << sq_shift;
      sq_try    = {1'b0, sqr_ff} + {1'b0, sq_bit};
      sq_r_next = ({1'b0, sqv_ff} >= sq_try) ? ((sqr_ff >> 1) + sq_bit) : (sqr_ff >> 1);
      rem2      = {rem_ff, 1'b0};
      num       = mag_ff - 16'(dz_ff);
      msb       = '0;
      for (int i = 0; i < 16; i++) begin
         if (nrm_ff[i]) msb = 4'(i);
      end
      idx_word  = {nrm_ff, 8'd0} >> msb;
      p_round   = {1'b0, pval_ff} + 26'd65535;
      s_val     = p_round[25:16];
      f_word    = {s_val, 16'd0} - {1'b0, pval_ff};
      exp_val   = ExpTab[f_word[15:8]] >> s_val[4:0];
      dq        = prod_ff[51:16];
      acc       = axis_ff ? ({21'd0, fracy_ff} - {dq[35], dq})
                          : ({21'd0, fracx_ff} + {dq[35], dq});
      abs_p     = prod_ff[51] ? (52'd0 - prod_ff) : prod_ff;
      trunc_v   = prod_ff[51] ? (21'd0 - {1'b0, abs_p[51:32]}) : {1'b0, abs_p[51:32]};

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               job_in   = q_job;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            lsq_in   = mul_p[31:0];
            state_in = S_SQY;
         end
         S_SQY: begin
            lsq_in   = lsq_ff + mul_p[31:0];
            state_in = S_DZSQ;
         end
         S_DZSQ: begin
            if (lsq_ff > mul_p[31:0]) begin
               sqv_in   = lsq_ff;
               sqr_in   = '0;
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               nrm_in   = '0;
               axis_in  = 1'b0;
               state_in = S_P1;
            end
         end
         S_SQRT: begin
            if ({1'b0, sqv_ff} >= sq_try) sqv_in = sqv_ff - sq_try[31:0];
            sqr_in = sq_r_next;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               mag_in   = sq_r_next[15:0];
               dz_in    = job_ff.pdz;
               tgt_in   = 1'b0;
               state_in = S_NRM;
            end
         end
         S_NRM: begin
            den_in = FullScale - dz_ff;
            priority if (mag_ff <= 16'(dz_ff)) begin
               nrm_in   = '0;
               state_in = S_NDONE;
            end else if (dz_ff >= FullScale || num >= 16'(FullScale - dz_ff)) begin
               nrm_in   = 16'hffff;
               state_in = S_NDONE;
            end else begin
               rem_in   = num;
               nrm_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem2 >= 17'(den_ff)) begin
               rem_in = 16'(rem2 - 17'(den_ff));
               nrm_in = {nrm_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2[15:0];
               nrm_in = {nrm_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = S_NDONE;
         end
         S_NDONE: begin
            if (tgt_ff) begin
               state_in = S_SM1;
            end else if (cfg.curve_exponent != '0 && nrm_ff != '0) begin
               state_in = S_CV1;
            end else begin
               axis_in  = 1'b0;
               state_in = S_P1;
            end
         end
         S_CV1: begin
            lval_in  = {5'd16 - {1'b0, msb}, 16'd0} - {5'd0, LogTab[idx_word[7:0]]};
            state_in = S_CV2;
         end
         S_CV2: begin
            pval_in  = mul_p[32:8];
            state_in = S_CV3;
         end
         S_CV3: begin
            if (s_val >= 10'd18) nrm_in = '0;
            else if (exp_val[16]) nrm_in = 16'hffff;
            else nrm_in = exp_val[15:0];
            axis_in  = 1'b0;
            state_in = S_P1;
         end
         S_P1: begin
            tn_in    = mul_p[32:0];
            state_in = S_P2;
         end
         S_P2: begin
            prod_in  = mul_p;
            state_in = S_P3;
         end
         S_P3: begin
            if (axis_ff) begin
               fracy_in = acc[15:0];
               stepy_in = sat16(acc[36:16]);
               axis_in  = 1'b0;
               state_in = S_SC;
            end else begin
               fracx_in = acc[15:0];
               stepx_in = sat16(acc[36:16]);
               axis_in  = 1'b1;
               state_in = S_P1;
            end
         end
         S_SC: begin
            if (axis_ff ? job_ff.ven : job_ff.hen) begin
               mag_in   = axis_ff ? job_ff.smy : job_ff.smx;
               dz_in    = job_ff.sdz;
               tgt_in   = 1'b1;
               state_in = S_NRM;
            end else begin
               if (axis_ff) vval_in = '0;
               else hval_in = '0;
               axis_in  = 1'b1;
               state_in = axis_ff ? S_OUT : S_SC;
            end
         end
         S_SM1: begin
            tn_in    = mul_p[32:0];
            state_in = S_SM2;
         end
         S_SM2: begin
            prod_in  = mul_p;
            state_in = S_SM3;
         end
         S_SM3: begin
            if (axis_ff) vval_in = sat16(trunc_v);
            else hval_in = sat16(trunc_v);
            axis_in  = 1'b1;
            state_in = axis_ff ? S_OUT : S_SC;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in.pointer_step_x          = stepx_ff;
               rsp_in.pointer_step_y          = stepy_ff;
               rsp_in.scroll_horizontal       = hval_ff;
               rsp_in.scroll_horizontal_valid = job_ff.hen;
               rsp_in.scroll_vertical         = vval_ff;
               rsp_in.scroll_vertical_valid   = job_ff.ven;
               rsp_valid_in                   = 1'b1;
               state_in                       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fracx_ff     <= '0;
         fracy_ff     <= '0;
         axis_ff      <= 1'b0;
         tgt_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fracx_ff     <= fracx_in;
         fracy_ff     <= fracy_in;
         axis_ff      <= axis_in;
         tgt_ff       <= tgt_in;
         cnt_ff       <= cnt_in;
      end
      job_ff   <= job_in;
      lsq_ff   <= lsq_in;
      sqv_ff   <= sqv_in;
      sqr_ff   <= sqr_in;
      mag_ff   <= mag_in;
      dz_ff    <= dz_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      nrm_ff   <= nrm_in;
      lval_ff  <= lval_in;
      pval_ff  <= pval_in;
      tn_ff    <= tn_in;
      prod_ff  <= prod_in;
      stepx_ff <= stepx_in;
      stepy_ff <= stepy_in;
      hval_ff  <= hval_in;
      vval_ff  <= vval_in;
      rsp_ff   <= rsp_in;
   end

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> rem_ff < 16'(den_ff))
      else $error("divider remainder not below divisor");
   a_one_scroll_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SC) |-> !(job_ff.hen && job_ff.ven))
      else $error("both scroll axes issued");
   a_sqrt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NRM && !tgt_ff) |-> 32'(mag_ff) * 32'(mag_ff) <= lsq_ff)
      else $error("square root too large");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_SQX)
      else $error("job taken without starting");

endmodule

@@ rtl/stick_to_pointer_motion.sv @@
// Top level of the stick-to-pointer motion block: registers, front, queue, back.
//
//  Port group | Direction | Handshake           | Payload
//  req_*      | in        | req_valid/req_stall | stpm_req_type (four stick axes)
//  rsp_*      | out       | rsp_valid/rsp_stall | stpm_rsp_type (pointer steps, wheel)
//  csr_*      | in        | csr_write_enable    | csr_index, csr_write_data (16 bits)
//
// The back end takes one sample at a time through the 16-step square root and the
// 16-step shared divider (run at most once each for the pointer and for scroll)
// around a single shared multiplier. The front and a two-entry queue take samples
// while the back works. Reset is synchronous, clears the fractions and loads the
// register defaults. A waiting result stalls only the final hand-off of the next one.
module stick_to_pointer_motion import stpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  stpm_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output stpm_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_write_data
);

   stpm_cfg_type cfg_ff, cfg_in;
   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_valid;
   stpm_job_type push_job;
   stpm_job_type head_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrSwapSticks:    cfg_in.swap_sticks       = csr_write_data[0];
            CsrPointerDz:     cfg_in.pointer_dead_zone = csr_write_data[14:0];
            CsrScrollDz:      cfg_in.wheel_dead_zone   = csr_write_data[14:0];
            CsrPointerGain:   cfg_in.pointer_gain      = csr_write_data;
            CsrScrollGain:    cfg_in.scroll_gain       = csr_write_data;
            CsrCurveExponent: cfg_in.curve_exponent    = csr_write_data[11:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_sticks       <= 1'b0;
         cfg_ff.pointer_dead_zone <= 15'd6000;
         cfg_ff.wheel_dead_zone   <= 15'd5000;
         cfg_ff.pointer_gain      <= 16'd655;
         cfg_ff.scroll_gain       <= 16'd655;
         cfg_ff.curve_exponent    <= 12'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stpm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   stpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_job)
   );

   stpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the stick-to-pointer motion block.
module tb_top;
   import stpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CsrSpareA = 3'd6;
   localparam logic [2:0] CsrSpareB = 3'd7;
   localparam int PhaseCount = 8;
   localparam int PhaseItems = 210;
   localparam int DirectedRows = 15;

   typedef struct {
      stpm_req_type sample;
      bit           typed;
      stpm_rsp_type motion;
   } directed_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   stpm_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   stpm_rsp_type rsp_data;
   logic         csr_write_enable;
   logic [2:0]   csr_index;
   logic [15:0]  csr_write_data;

   stpm_cfg_type     cfg_shadow;
   longint           frac_x;
   longint           frac_y;
   longint unsigned  log_t [CurveEntries];
   longint unsigned  exp_t [CurveEntries];
   stpm_rsp_type     motion_expected [$];
   directed_row_type rows [DirectedRows];
   int               error_count;
   int               samples_sent;
   int               motions_seen;
   int               wheel_events;
   bit               idle_enable;

   stick_to_pointer_motion uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v_in);
      longint unsigned v, r, b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Log2 and exp2 tables by repeated squaring and chained square roots.
   function automatic void build_curve_tables();
      longint unsigned root [17];
      longint unsigned y, f16, r, res;
      root[1] = int_sqrt(64'd1 << 61);
      for (int k = 2; k <= 16; k++) root[k] = int_sqrt(root[k-1] << 30);
      for (int i = 0; i < CurveEntries; i++) begin
         y   = (64'd1 << 30) + ((longint'(i) << 30) / CurveEntries);
         f16 = (longint'(i) << 16) / CurveEntries;
         r   = 64'd1 << 30;
         res = 0;
         for (int k = 1; k <= 16; k++) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
               y = y >> 1;
               res = res | (64'd1 << (16 - k));
            end
            if ((f16 >> (16 - k)) & 1) r = (r * root[k]) >> 30;
         end
         log_t[i] = res;
         exp_t[i] = r >> 14;
      end
   endfunction

   function automatic longint scale_excess(longint mag, longint dz);
      longint q;
      if (mag <= dz) return 0;
      if (dz >= longint'(FullScale)) return 65535;
      q = ((mag - dz) << 16) / (longint'(FullScale) - dz);
      return (q > 65535) ? 65535 : q;
   endfunction

   function automatic longint curve_lookup(longint n, longint e);
      longint unsigned lv, pv, s, f, r;
      int p;
      longint idx, j;
      if (n == 0) return 0;
      p = 0;
      while ((n >> (p + 1)) != 0) p++;
      idx = ((n - (longint'(1) << p)) * CurveEntries) >> p;
      lv = (longint'(16 - p) << 16) - log_t[idx];
      pv = (lv * e) >> 8;
      s  = (pv + 65535) >> 16;
      if (s >= 18) return 0;
      f = (s << 16) - pv;
      j = (f * CurveEntries) >> 16;
      r = exp_t[j] >> s;
      return (r > 65535) ? 65535 : r;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint wheel_amount(longint axis, longint mag, longint dz,
                                           longint gain);
      longint v;
      v = axis * scale_excess(mag, dz) * gain;
      v = (v >= 0) ? (v >>> 32) : -((-v) >>> 32);
      return clamp16(v);
   endfunction

   // Advance the fraction accumulators and return the motion for one sample.
   function automatic stpm_rsp_type predict_motion(stpm_req_type s);
      stpm_rsp_type m;
      longint px, py, sx, sy, pdz, sdz, lsq, n, dxq, dyq, ax, ay, stx, sty, mx, my;
      px  = cfg_shadow.swap_sticks ? s.right_x : s.left_x;
      py  = cfg_shadow.swap_sticks ? s.right_y : s.left_y;
      sx  = cfg_shadow.swap_sticks ? s.left_x : s.right_x;
      sy  = cfg_shadow.swap_sticks ? s.left_y : s.right_y;
      pdz = (cfg_shadow.pointer_dead_zone != 0) ? cfg_shadow.pointer_dead_zone
                                                : DefaultPointerDz;
      sdz = (cfg_shadow.wheel_dead_zone != 0) ? cfg_shadow.wheel_dead_zone
                                              : DefaultScrollDz;
      lsq = px * px + py * py;
      n = 0;
      if (lsq > pdz * pdz) begin
         n = scale_excess(longint'(int_sqrt(lsq)), pdz);
         if (cfg_shadow.curve_exponent != 0) n = curve_lookup(n, cfg_shadow.curve_exponent);
      end
      dxq = (px * n * longint'(cfg_shadow.pointer_gain)) >>> 16;
      dyq = (py * n * longint'(cfg_shadow.pointer_gain)) >>> 16;
      ax  = frac_x + dxq;
      ay  = frac_y - dyq;
      stx = ax >>> 16;
      sty = ay >>> 16;
      frac_x = ax - stx * 65536;
      frac_y = ay - sty * 65536;
      m = '0;
      m.pointer_step_x = 16'(clamp16(stx));
      m.pointer_step_y = 16'(clamp16(sty));
      mx = (sx < 0) ? -sx : sx;
      my = (sy < 0) ? -sy : sy;
      // horizontal gives up on a tie
      if (mx > sdz && my > sdz) begin
         if (mx > my) my = 0;
         else mx = 0;
      end
      if (mx > sdz) begin
         m.scroll_horizontal = 16'(wheel_amount(sx, mx, sdz, cfg_shadow.scroll_gain));
         m.scroll_horizontal_valid = 1'b1;
      end
      if (my > sdz) begin
         m.scroll_vertical = 16'(wheel_amount(sy, my, sdz, cfg_shadow.scroll_gain));
         m.scroll_vertical_valid = 1'b1;
      end
      return m;
   endfunction

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1: return 16'($urandom_range(0, 12000)) - 16'd6000;
         2: return 16'($urandom_range(2000, 9000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got),
               $signed(want), $realtime);
      error_count++;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = val;
      case (idx)
         CsrSwapSticks:    cfg_shadow.swap_sticks = val[0];
         CsrPointerDz:     cfg_shadow.pointer_dead_zone = val[14:0];
         CsrScrollDz:      cfg_shadow.wheel_dead_zone = val[14:0];
         CsrPointerGain:   cfg_shadow.pointer_gain = val;
         CsrScrollGain:    cfg_shadow.scroll_gain = val;
         CsrCurveExponent: cfg_shadow.curve_exponent = val[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Hold valid until the transaction is taken; predict at the accepting edge.
   task automatic send_sample(stpm_req_type s, bit typed, stpm_rsp_type want);
      stpm_rsp_type m;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = s;
      do @(posedge clock); while (req_stall);
      m = predict_motion(s);
      motion_expected.insert(motion_expected.size(), typed ? want : m);
      samples_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain();
      while (motion_expected.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // receiver stall bursts
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
         end else if (idle_enable && $urandom_range(0, 6) == 0) begin
            burst = $urandom_range(1, 17);
         end
         rsp_stall = (burst > 0);
      end
   end

   always @(posedge clock) begin
      stpm_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         motions_seen++;
         if (motion_expected.size() == 0) begin
            $display("unexpected motion transaction at %0t", $realtime);
            error_count++;
         end else begin
            w = motion_expected.pop_front();
            if (rsp_data.scroll_horizontal_valid || rsp_data.scroll_vertical_valid)
               wheel_events++;
            if (rsp_data.pointer_step_x !== w.pointer_step_x)
               report("pointer_step_x", rsp_data.pointer_step_x, w.pointer_step_x);
            if (rsp_data.pointer_step_y !== w.pointer_step_y)
               report("pointer_step_y", rsp_data.pointer_step_y, w.pointer_step_y);
            if (rsp_data.scroll_horizontal !== w.scroll_horizontal)
               report("scroll_horizontal", rsp_data.scroll_horizontal,
                      w.scroll_horizontal);
            if (rsp_data.scroll_horizontal_valid !== w.scroll_horizontal_valid)
               report("scroll_horizontal_valid", 16'(rsp_data.scroll_horizontal_valid),
                      16'(w.scroll_horizontal_valid));
            if (rsp_data.scroll_vertical !== w.scroll_vertical)
               report("scroll_vertical", rsp_data.scroll_vertical, w.scroll_vertical);
            if (rsp_data.scroll_vertical_valid !== w.scroll_vertical_valid)
               report("scroll_vertical_valid", 16'(rsp_data.scroll_vertical_valid),
                      16'(w.scroll_vertical_valid));
         end
      end
   end

   initial begin
      logic [15:0] setting [PhaseCount][6];
      stpm_req_type s;
      stpm_rsp_type none;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = CsrSwapSticks;
      csr_write_data = '0;
      error_count = 0;
      samples_sent = 0;
      motions_seen = 0;
      wheel_events = 0;
      idle_enable = 1'b1;
      frac_x = 0;
      frac_y = 0;
      none = '0;
      cfg_shadow = '{1'b0, DefaultPointerDz, DefaultScrollDz, 16'd655, 16'd655, 12'd0};
      build_curve_tables();

      // directed samples under the reset settings
      foreach (rows[i]) rows[i] = '{'0, 1'b0, '0};
      rows[1].sample.right_x = 16'sd32767;
      rows[1].typed = 1'b1;
      rows[1].motion.scroll_horizontal = 16'sd327;
      rows[1].motion.scroll_horizontal_valid = 1'b1;
      rows[2].sample.right_x = -16'sd32768;
      rows[2].typed = 1'b1;
      rows[2].motion.scroll_horizontal = -16'sd327;
      rows[2].motion.scroll_horizontal_valid = 1'b1;
      rows[3].sample.right_y = 16'sd32767;
      rows[3].typed = 1'b1;
      rows[3].motion.scroll_vertical = 16'sd327;
      rows[3].motion.scroll_vertical_valid = 1'b1;
      rows[4].sample.right_y = -16'sd32768;
      rows[4].typed = 1'b1;
      rows[4].motion.scroll_vertical = -16'sd327;
      rows[4].motion.scroll_vertical_valid = 1'b1;
      rows[0].typed = 1'b1;
      rows[5].sample.right_x = 16'sd5000;
      rows[5].typed = 1'b1;
      rows[6].sample.right_x = 16'sd5001;
      rows[7].sample = '{16'sd0, 16'sd0, 16'sd10000, -16'sd10000};
      rows[8].sample = '{16'sd0, 16'sd0, 16'sd20000, 16'sd9000};
      rows[9].sample.left_x = 16'sd32767;
      rows[10].sample = '{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0};
      rows[11].sample = '{16'sd4242, 16'sd4243, 16'sd0, 16'sd0};
      rows[12].sample = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd32767};
      rows[13].sample = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      rows[14].sample = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};

      // settings per phase, in register order; wide values check masking
      setting[1] = '{16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd4095};
      setting[2] = '{16'hFFFE, 16'hFFFF, 16'd32766, 16'd0, 16'd0, 16'hF001};
      setting[3] = '{16'd1, 16'd0, 16'd0, 16'd655, 16'd40000, 16'd256};
      setting[6] = '{16'd0, 16'd3000, 16'd3000, 16'd20000, 16'd20000, 16'd0};
      foreach (setting[p]) begin
         if (p == 0 || p == 4 || p == 5 || p == PhaseCount - 1) begin
            setting[p][0] = 16'($urandom_range(0, 1));
            setting[p][1] = 16'($urandom_range(1, 32766));
            setting[p][2] = 16'($urandom_range(1, 32766));
            setting[p][3] = 16'($urandom);
            setting[p][4] = 16'($urandom);
            setting[p][5] = (p == 4) ? 16'd384 : 16'($urandom_range(0, 4095));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].motion);

      for (int p = 1; p < PhaseCount; p++) begin
         drain();
         if (p == 2) begin
            csr_write(CsrSpareA, 16'hFFFF);
            csr_write(CsrSpareB, 16'h1234);
         end
         csr_write(CsrSwapSticks, setting[p][0]);
         csr_write(CsrPointerDz, setting[p][1]);
         csr_write(CsrScrollDz, setting[p][2]);
         csr_write(CsrPointerGain, setting[p][3]);
         csr_write(CsrScrollGain, setting[p][4]);
         csr_write(CsrCurveExponent, setting[p][5]);
         idle_enable = (p != PhaseCount - 1);
         for (int i = 0; i < PhaseItems + 40; i++) begin
            s.left_x = rand_axis();
            s.left_y = rand_axis();
            s.right_x = rand_axis();
            s.right_y = rand_axis();
            send_sample(s, 1'b0, none);
         end
      end

      drain();
      $display("samples %0d, motion transactions %0d, with wheel events %0d",
               samples_sent, motions_seen, wheel_events);
      $display("covered %0d register settings incl. extremes, swap and curve", PhaseCount);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/stpm_pkg.sv
rtl/stpm_front.sv
rtl/stpm_queue.sv
rtl/stpm_back.sv
rtl/stick_to_pointer_motion.sv
tb/sv/tb_top.sv
